### hdl/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### hdl/sbmp_pkg.sv
// Package with constants and tables of the spectrum bin magnitude and phase block.
package sbmp_pkg;
  localparam int SampleBitsDef  = 24;
  localparam int CordicStepsDef = 16;
  localparam int OutBits        = 26;
  localparam int AngBits        = 23;
  localparam int PhaseBits      = 16;
  localparam int InvGain        = 39797;
  localparam logic [1:0] ModeMag   = 2'd0;
  localparam logic [1:0] ModePhase = 2'd1;
  localparam logic [1:0] ModeDiff  = 2'd2;

  // Arctangent table, pi equals 2^20.
  function automatic logic [AngBits-1:0] atan_lut(input logic [4:0] idx);
    logic [AngBits-1:0] v;
    case (idx)
      5'd0: v = 23'd262144;  5'd1: v = 23'd154753; 5'd2: v = 23'd81767;
      5'd3: v = 23'd41506;   5'd4: v = 23'd20834;  5'd5: v = 23'd10427;
      5'd6: v = 23'd5215;    5'd7: v = 23'd2608;   5'd8: v = 23'd1304;
      5'd9: v = 23'd652;     5'd10: v = 23'd326;   5'd11: v = 23'd163;
      5'd12: v = 23'd81;     5'd13: v = 23'd41;    5'd14: v = 23'd20;
      5'd15: v = 23'd10;     5'd16: v = 23'd5;     5'd17: v = 23'd3;
      5'd18: v = 23'd1;      5'd19: v = 23'd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

### hdl/spectrum_bin_mag_phase_unwrap.sv
// Top level of the spectrum bin magnitude and phase block.
//
// Input channel in_*: one complex bin per transfer with a first-bin flag.
// Result channel out_*: one bin_value per input transfer, in order.
// Configuration port cfg_*: APB-style, register 0 (output_mode) at address 0;
// write it only while the block is idle.
// Each bin runs through an iterative CORDIC engine: a load, then CORDIC_STEPS
// rotation steps at one per cycle, then a multiply for the gain correction
// and a final state that unwraps, filters and registers the result.
// All rotation steps share a single shift-add unit; one item is in work at a
// time.
// Synchronous reset clears the mode, the phase memory and the filter memory.
// The result waits in the output register while the receiver stalls; the next
// input is taken meanwhile and its result holds in the engine until the
// output register frees.
module spectrum_bin_mag_phase_unwrap
  import sbmp_pkg::*;
#(
  parameter int SAMPLE_BITS  = SampleBitsDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_bin_real,
  input  logic signed [SAMPLE_BITS-1:0] in_bin_imag,
  input  logic                          in_first_bin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OutBits-1:0]     out_bin_value,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  localparam int XW = SAMPLE_BITS + 3;
  localparam int CW = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_ITER = 4'b0010, ST_MUL = 4'b0100, ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] mode_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [AngBits-1:0] z_r;
  logic [CW-1:0] cnt_r;
  logic first_r, zero_r;
  logic signed [XW+17:0] prod_r;
  logic signed [17:0] prev_r;
  logic signed [18:0] dmem_r;
  logic signed [OutBits-1:0] out_r;
  logic out_valid_r;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {30'd0, mode_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeMag;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Rotation step shifts.
  logic signed [XW-1:0] dx, dy;
  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;

  // Raw phase, unwrap, filter, magnitude rounding and output selection.
  logic signed [AngBits-1:0] zr;
  logic signed [PhaseBits-1:0] raw;
  logic signed [17:0] rawx, d, unw;
  logic signed [18:0] diff;
  logic signed [XW+1:0] mag;
  logic signed [OutBits-1:0] res;
  always_comb begin
    zr   = (z_r + AngBits'(16)) >>> 5;
    raw  = zero_r ? '0 : zr[PhaseBits-1:0];
    rawx = 18'(raw);
    d    = rawx - prev_r;
    if (d > 18'sd32768) d = d - 18'sd65536;
    else if (d < -18'sd32768) d = d + 18'sd65536;
    unw  = first_r ? rawx : prev_r + d;
    diff = 19'(unw) - dmem_r;
    mag  = zero_r ? '0 : (XW+2)'((prod_r + (XW+18)'(32768)) >>> 16);
    case (mode_r)
      ModePhase: res = OutBits'(unw);
      ModeDiff:  res = OutBits'(diff);
      default: begin
        if (mag > (XW+2)'(33554431)) res = 26'sd33554431;
        else res = OutBits'(mag);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_ITER;
      ST_ITER: if (cnt_r == CW'(CORDIC_STEPS - 1)) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      prev_r <= '0;
      dmem_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        prev_r <= rawx;
        if (mode_r == ModeDiff) dmem_r <= 19'(unw);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // CORDIC datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cnt_r <= '0;
        first_r <= in_first_bin;
        zero_r <= (in_bin_real == '0) && (in_bin_imag == '0);
        if (in_bin_real < 0) begin
          x_r <= -XW'(in_bin_real);
          y_r <= -XW'(in_bin_imag);
          z_r <= (in_bin_imag >= 0) ? AngBits'(1048576) : -AngBits'(1048576);
        end else begin
          x_r <= XW'(in_bin_real);
          y_r <= XW'(in_bin_imag);
          z_r <= '0;
        end
      end
      ST_ITER: begin
        cnt_r <= cnt_r + 1'b1;
        if (y_r > 0) begin
          x_r <= x_r + dx; y_r <= y_r - dy;
          z_r <= z_r + atan_lut(5'(cnt_r));
        end else begin
          x_r <= x_r - dx; y_r <= y_r + dy;
          z_r <= z_r - atan_lut(5'(cnt_r));
        end
      end
      ST_MUL: prod_r <= (XW+18)'(x_r) * (XW+18)'(InvGain);
      default: ;
    endcase
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_bin_value = out_r;

`include "assert_macros.svh"
  `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, in_ready, state_r == ST_IDLE)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(out_r))
  `ASSERT_IMPLIES(a_cnt, clk, rst_n, state_r == ST_ITER, cnt_r < CW'(CORDIC_STEPS))
endmodule

### tb/spectrum_bin_mag_phase_unwrap_test.sv
// Self-checking testbench of the spectrum bin magnitude and phase block.
`timescale 1ns / 1ps

module spectrum_bin_mag_phase_unwrap_test;
  import sbmp_pkg::*;

  localparam logic [1:0] ModeMagAlt = 2'd3;
  localparam logic [2:0] AddrMode   = 3'd0;
  localparam logic [2:0] AddrUnused = 3'd4;
  localparam longint AnglePi = 1048576;
  localparam longint OutMax  = 33554431;
  localparam longint OutMin  = -33554432;
  localparam int DrainCycles = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] in_bin_real = '0;
  logic signed [23:0] in_bin_imag = '0;
  logic in_first_bin = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OutBits-1:0] out_bin_value;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Predictor state: the block's mode, last raw phase and filter memory.
  logic [1:0] mode_copy = ModeMag;
  longint last_raw_phase = 0;
  longint filter_memory = 0;
  logic [OutBits-1:0] expected_values[$];
  int mismatch_count = 0;
  bit idle_on = 1'b1;

  // Arctangent of 2^-i with pi equal to 2^20.
  longint arctan_steps[16] = '{262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
                               1304, 652, 326, 163, 81, 41, 20, 10};

  spectrum_bin_mag_phase_unwrap uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_bin_real(in_bin_real), .in_bin_imag(in_bin_imag), .in_first_bin(in_first_bin),
    .out_valid(out_valid), .out_ready(out_ready), .out_bin_value(out_bin_value),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Vectoring CORDIC: rotates the bin onto the real axis, giving gain-corrected
  // magnitude and raw phase with pi equal to 32768.
  function automatic void polar_of_bin(input longint re, input longint im,
                                       output longint mag, output longint phase);
    longint x, y, z, dx, dy, zr;
    x = re;
    y = im;
    z = 0;
    if (re == 0 && im == 0) begin
      mag = 0;
      phase = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? AnglePi : -AnglePi;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += arctan_steps[i];
      end else begin
        x -= dx;
        y += dy;
        z -= arctan_steps[i];
      end
    end
    mag = (x * 39797 + 32768) >>> 16;
    zr = (z + 16) >>> 5;
    phase = longint'(shortint'(zr[15:0]));
  endfunction

  // Works out the bin_value of one accepted bin and advances the phase state.
  function automatic logic [OutBits-1:0] predict_bin(input logic signed [23:0] re,
                                                     input logic signed [23:0] im,
                                                     input logic first);
    longint mag, raw, unwrapped, delta, value;
    polar_of_bin(longint'(re), longint'(im), mag, raw);
    if (first) begin
      unwrapped = raw;
    end else begin
      delta = raw - last_raw_phase;
      if (delta > 32768) delta -= 65536;
      else if (delta < -32768) delta += 65536;
      unwrapped = last_raw_phase + delta;
    end
    last_raw_phase = raw;
    case (mode_copy)
      ModePhase: value = unwrapped;
      ModeDiff: begin
        value = unwrapped - filter_memory;
        filter_memory = unwrapped;
      end
      default: value = mag;
    endcase
    if (value > OutMax) value = OutMax;
    if (value < OutMin) value = OutMin;
    return value[OutBits-1:0];
  endfunction

  // Sends one bin; entered and left just after a falling edge.
  task automatic send_bin(input logic [23:0] re, input logic [23:0] im, input logic first);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_bin_real <= re;
    in_bin_imag <= im;
    in_first_bin <= first;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    expected_values.push_back(predict_bin(re, im, first));
    @(negedge clk);
  endtask

  // Lowers valid, waits for every expected result and lets the engine settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // APB write followed by a read-back of the mode register.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (addr == AddrMode) mode_copy = value[1:0];
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr <= AddrMode;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[1:0] !== mode_copy) report_mismatch("output_mode read", cfg_prdata,
                                                       {30'd0, mode_copy});
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Random sample: full-range bits, tiny values, extremes or a mid-range value.
  function automatic logic [23:0] random_sample();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      1: return 24'($signed($urandom_range(0, 64)) - 32);
      2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return 24'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  task automatic test_magnitude_extremes();
    write_register(AddrMode, ModeMag);
    send_bin(24'h7fffff, 24'h7fffff, 1'b1);
    send_bin(24'h800000, 24'h800000, 1'b0);
    send_bin(24'h800000, 24'h000000, 1'b0);
    send_bin(24'h000000, 24'h000000, 1'b0);
    send_bin(24'h7fffff, 24'h000000, 1'b0);
    send_bin(24'h000000, 24'h800000, 1'b0);
    send_bin(24'h000000, 24'h7fffff, 1'b1);
    send_bin(24'hffffff, 24'hffffff, 1'b0);
    wait_idle();
  endtask

  // Phases that straddle pi force the unwrap to add or remove a full turn.
  task automatic test_phase_wrap();
    write_register(AddrMode, ModePhase);
    send_bin(-24'sd1000, 24'sd10, 1'b1);
    send_bin(-24'sd1000, -24'sd10, 1'b0);
    send_bin(-24'sd1000, 24'sd10, 1'b0);
    send_bin(-24'sd1000, 24'sd0, 1'b0);
    send_bin(24'sd0, 24'sd0, 1'b0);
    send_bin(-24'sd1000, -24'sd10, 1'b1);
    wait_idle();
  endtask

  // The filter memory must carry across a frame start.
  task automatic test_phase_difference();
    write_register(AddrMode, ModeDiff);
    send_bin(24'sd500, 24'sd500, 1'b1);
    send_bin(-24'sd500, 24'sd500, 1'b0);
    send_bin(-24'sd500, -24'sd500, 1'b0);
    send_bin(24'sd500, -24'sd1, 1'b1);
    send_bin(24'h800000, 24'h7fffff, 1'b0);
    wait_idle();
  endtask

  // Mode three acts as magnitude; a write to an unused address changes nothing.
  task automatic test_alternate_magnitude();
    write_register(AddrMode, ModeMagAlt);
    write_register(AddrUnused, 32'hffffffff);
    send_bin(24'sd3, -24'sd4, 1'b1);
    send_bin(24'h7fffff, 24'h800000, 1'b0);
    send_bin(24'h123456, 24'hfedcba, 1'b0);
    wait_idle();
  endtask

  // Frames of random length with random bins, under one mode.
  task automatic run_frames(input logic [1:0] mode, input int count);
    int left;
    bit start;
    write_register(AddrMode, mode);
    left = 0;
    for (int n = 0; n < count; n++) begin
      start = (left == 0);
      if (left == 0) left = $urandom_range(1, 16);
      send_bin(random_sample(), random_sample(), start || $urandom_range(0, 15) == 0);
      left--;
    end
    wait_idle();
  endtask

  task automatic test_random_modes();
    run_frames(ModePhase, 110);
    run_frames(ModeMag, 90);
    run_frames(ModeDiff, 110);
    run_frames(ModeMagAlt, 60);
    run_frames(ModeDiff, 90);
  endtask

  task automatic test_streaming();
    idle_on = 1'b0;
    run_frames(ModePhase, 60);
    run_frames(ModeDiff, 60);
  endtask

  // Receiver stalls in random bursts while idling is enabled.
  always @(negedge clk) begin
    static int stall_left = 0;
    if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each result transfer is compared with the oldest expected value.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_values.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_bin_value), 32'd0);
      end else if (out_bin_value !== expected_values[0]) begin
        report_mismatch("bin_value", 32'(out_bin_value), 32'(expected_values[0]));
        void'(expected_values.pop_front());
      end else begin
        void'(expected_values.pop_front());
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_magnitude_extremes();
    test_phase_wrap();
    test_phase_difference();
    test_alternate_magnitude();
    test_random_modes();
    test_streaming();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
